>>> hdl/fclb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fclb_pkg: shared types and constants of the LED blink engine
// Holds the duration width, the rate table, the reset values and the opcode.
// ----------------------------------------------------------------------------
package fclb_pkg;

  localparam int unsigned DUR_W  = 22;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned MASK_W = 4;

  localparam logic [DUR_W-1:0] T_HALF_S  = 22'd500000;
  localparam logic [DUR_W-1:0] T_ONE_S   = 22'd1000000;
  localparam logic [DUR_W-1:0] T_THREE_S = 22'd3000000;
  localparam logic [DUR_W-1:0] T_QUART_S = DUR_W'(1000000 / 4);
  localparam logic [DUR_W-1:0] T_EIGHT_S = DUR_W'(1000000 / 8);
  localparam logic [DUR_W-1:0] T_SIXT_S  = DUR_W'(1000000 / 16);
  localparam logic [DUR_W-1:0] T_250MS   = 22'd250000;
  localparam logic [DUR_W-1:0] T_100MS   = 22'd100000;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_RECONF = 1'b1
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_1HZ    = 3'd0,
    MODE_HALFHZ = 3'd1,
    MODE_2HZ    = 3'd2,
    MODE_4HZ    = 3'd3,
    MODE_8HZ    = 3'd4,
    MODE_QUARTHZ = 3'd5
  } mode_t;

  // Registered copy of one input item.
  typedef struct packed {
    logic                          opcode;
    logic [MASK_W-1:0]             changed_mask;
    logic [MASK_W-1:0]             colour_mask;
    logic [MASK_W-1:0][MODE_W-1:0] mode;
  } item_t;

  // Resynchronization control handed from the reference search to each LED.
  typedef struct packed {
    logic none;     // every LED is flagged
    logic ref_lit;  // lit bit of the reference LED
  } sync_t;

  function automatic logic [DUR_W-1:0] rate_on(input logic [MODE_W-1:0] mode);
    logic [DUR_W-1:0] d;
    case (mode)
      MODE_1HZ:     d = T_HALF_S;
      MODE_HALFHZ:  d = T_ONE_S;
      MODE_2HZ:     d = T_QUART_S;
      MODE_4HZ:     d = T_EIGHT_S;
      MODE_8HZ:     d = T_SIXT_S;
      MODE_QUARTHZ: d = T_ONE_S;
      default:      d = T_ONE_S;
    endcase
    return d;
  endfunction

  function automatic logic [DUR_W-1:0] rate_off(input logic [MODE_W-1:0] mode);
    logic [DUR_W-1:0] d;
    case (mode)
      MODE_1HZ:     d = T_HALF_S;
      MODE_HALFHZ:  d = T_ONE_S;
      MODE_2HZ:     d = T_QUART_S;
      MODE_4HZ:     d = T_EIGHT_S;
      MODE_8HZ:     d = T_SIXT_S;
      MODE_QUARTHZ: d = T_THREE_S;
      default:      d = T_ONE_S;
    endcase
    return d;
  endfunction

  function automatic logic [DUR_W-1:0] reset_dur(input logic [1:0] slot);
    logic [DUR_W-1:0] d;
    case (slot)
      2'd0:    d = T_ONE_S;
      2'd1:    d = T_250MS;
      2'd2:    d = T_ONE_S;
      default: d = T_100MS;
    endcase
    return d;
  endfunction

  function automatic logic reset_red(input logic [1:0] slot);
    return (slot == 2'd3);
  endfunction

endpackage

`default_nettype wire

>>> hdl/fclb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fclb_in_if: input channel of the LED blink engine
// Valid/ready channel carrying one tick or reconfigure item.
// ----------------------------------------------------------------------------
interface fclb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] changed_mask;
  logic [3:0] colour_mask;
  logic [2:0] mode_led0;
  logic [2:0] mode_led1;
  logic [2:0] mode_led2;
  logic [2:0] mode_led3;

  modport source (
    output valid, opcode, changed_mask, colour_mask,
           mode_led0, mode_led1, mode_led2, mode_led3,
    input  ready
  );
  modport sink (
    input  valid, opcode, changed_mask, colour_mask,
           mode_led0, mode_led1, mode_led2, mode_led3,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/fclb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fclb_out_if: result channel of the LED blink engine
// Valid/ready channel carrying the lit and colour masks after each item.
// ----------------------------------------------------------------------------
interface fclb_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] lit_mask;
  logic [3:0] red_mask;

  modport source (output valid, lit_mask, red_mask, input ready);
  modport sink   (input valid, lit_mask, red_mask, output ready);
endinterface

`default_nettype wire

>>> hdl/fclb_ref_sel.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fclb_ref_sel: reference LED search for resynchronization
// Finds the unflagged LED with the most time left, lowest index on ties.
// ----------------------------------------------------------------------------
module fclb_ref_sel
  import fclb_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 4
) (
  input  wire logic [DUR_W-1:0]    time_left [NUM_LEDS],
  input  wire logic [NUM_LEDS-1:0] cand,
  input  wire logic [NUM_LEDS-1:0] lit,
  output sync_t                    sync
);

  logic [NUM_LEDS-1:0] is_ref;

  // Every candidate is compared against every other one in parallel; the
  // winner beats all lower indexes strictly and all higher ones or ties them.
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      is_ref[i] = cand[i];
      for (int j = 0; j < NUM_LEDS; j++) begin
        if (j < i) begin
          if (cand[j] && !(time_left[i] > time_left[j])) is_ref[i] = 1'b0;
        end else if (j > i) begin
          if (cand[j] && (time_left[i] < time_left[j])) is_ref[i] = 1'b0;
        end
      end
    end
  end

  assign sync.none    = ~|cand;
  assign sync.ref_lit = |(is_ref & lit);

endmodule

`default_nettype wire

>>> hdl/fclb_led.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fclb_led: one LED channel
// Holds the durations, countdown, lit bit and colour of a single LED.
// ----------------------------------------------------------------------------
module fclb_led
  import fclb_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              opcode,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic              colour,
  input  wire logic              flagged,
  input  wire sync_t             sync,
  output logic [DUR_W-1:0]       time_left,
  output logic                   lit,
  output logic                   lit_nxt,
  output logic                   red_nxt
);

  localparam logic [1:0] SLOT = 2'(IDX % 4);

  logic [DUR_W-1:0] on_r, on_nxt;
  logic [DUR_W-1:0] off_r, off_nxt;
  logic [DUR_W-1:0] tl_r, tl_nxt;
  logic             lit_r;
  logic             red_r;
  logic [DUR_W-1:0] new_on, new_off;

  assign new_on  = rate_on(mode);
  assign new_off = rate_off(mode);

  always_comb begin
    on_nxt  = on_r;
    off_nxt = off_r;
    tl_nxt  = tl_r;
    lit_nxt = lit_r;
    red_nxt = red_r;
    if (opcode == OP_RECONF) begin
      on_nxt  = new_on;
      off_nxt = new_off;
      red_nxt = colour;
      if (sync.none) begin
        lit_nxt = 1'b0;
        tl_nxt  = new_off;
      end else if (flagged) begin
        lit_nxt = sync.ref_lit;
        tl_nxt  = sync.ref_lit ? new_on : new_off;
      end
    end else begin
      // A count of one or zero both expire, so the counter never wraps.
      if (tl_r <= DUR_W'(1)) begin
        lit_nxt = ~lit_r;
        tl_nxt  = lit_r ? off_r : on_r;
      end else begin
        tl_nxt = tl_r - DUR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r  <= reset_dur(SLOT);
      off_r <= reset_dur(SLOT);
      tl_r  <= reset_dur(SLOT);
      lit_r <= 1'b0;
      red_r <= reset_red(SLOT);
    end else if (en) begin
      on_r  <= on_nxt;
      off_r <= off_nxt;
      tl_r  <= tl_nxt;
      lit_r <= lit_nxt;
      red_r <= red_nxt;
    end
  end

  assign time_left = tl_r;
  assign lit       = lit_r;

endmodule

`default_nettype wire

>>> hdl/four_channel_led_blink_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_channel_led_blink_engine_core: multi-channel LED blink controller
// Counts down per-LED on/off times on ticks and resynchronizes on reconfigure.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle, back to back, while the result
// side takes its results; each item passes the input register and then the
// result register. The whole update of all LED counters, the reference
// search and the resynchronization happen in one pass between those two
// registers, so the state of item n is ready in time for item n+1. The
// result register lets a new item enter while the previous result waits.
// ----------------------------------------------------------------------------
module four_channel_led_blink_engine_core
  import fclb_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fclb_in_if.sink    in_ch,
  fclb_out_if.source out_ch
);

  localparam int unsigned OUT_LEDS = (NUM_LEDS < MASK_W) ? NUM_LEDS : MASK_W;

  item_t             item_r;
  logic              s1_v_r;
  logic              out_v_r;
  logic [MASK_W-1:0] lit_mask_r, lit_mask_nxt;
  logic [MASK_W-1:0] red_mask_r, red_mask_nxt;
  logic              in_fire;
  logic              s1_move;

  logic [DUR_W-1:0]    time_left [NUM_LEDS];
  logic [NUM_LEDS-1:0] lit_vec;
  logic [NUM_LEDS-1:0] lit_nxt_vec;
  logic [NUM_LEDS-1:0] red_nxt_vec;
  logic [NUM_LEDS-1:0] flag_vec;
  sync_t               sync;

  assign s1_move     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_move;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_v_r <= in_ch.valid;
      if (s1_move) out_v_r <= 1'b1;
      else if (out_ch.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.opcode       <= in_ch.opcode;
      item_r.changed_mask <= in_ch.changed_mask;
      item_r.colour_mask  <= in_ch.colour_mask;
      item_r.mode[0]      <= in_ch.mode_led0;
      item_r.mode[1]      <= in_ch.mode_led1;
      item_r.mode[2]      <= in_ch.mode_led2;
      item_r.mode[3]      <= in_ch.mode_led3;
    end
    if (s1_move) begin
      lit_mask_r <= lit_mask_nxt;
      red_mask_r <= red_mask_nxt;
    end
  end

  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
    logic colour;
    // LEDs past the fourth are never flagged and are set green on every reconfigure.
    if (g < MASK_W) begin : g_low
      assign flag_vec[g] = item_r.changed_mask[g];
      assign colour      = item_r.colour_mask[g];
    end else begin : g_high
      assign flag_vec[g] = 1'b0;
      assign colour      = 1'b0;
    end

    fclb_led #(
      .IDX (g)
    ) u_led (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (s1_move),
      .opcode    (item_r.opcode),
      .mode      (item_r.mode[g % 4]),
      .colour    (colour),
      .flagged   (flag_vec[g]),
      .sync      (sync),
      .time_left (time_left[g]),
      .lit       (lit_vec[g]),
      .lit_nxt   (lit_nxt_vec[g]),
      .red_nxt   (red_nxt_vec[g])
    );
  end

  fclb_ref_sel #(
    .NUM_LEDS (NUM_LEDS)
  ) u_ref_sel (
    .time_left (time_left),
    .cand      (~flag_vec),
    .lit       (lit_vec),
    .sync      (sync)
  );

  always_comb begin
    lit_mask_nxt = '0;
    red_mask_nxt = '0;
    for (int i = 0; i < OUT_LEDS; i++) begin
      lit_mask_nxt[i] = lit_nxt_vec[i];
      red_mask_nxt[i] = red_nxt_vec[i];
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.lit_mask = lit_mask_r;
  assign out_ch.red_mask = red_mask_r;

`ifndef ASSERT_OFF
  a_in_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r)
    else $error("accepted item did not reach the input register");

  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_ch.valid)
    else $error("advanced item did not produce a result");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_move |=> $stable(lit_vec))
    else $error("LED state changed without an item");

  a_all_flagged_off: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && item_r.opcode == OP_RECONF && sync.none) |=> (lit_vec == '0))
    else $error("all-flagged reconfigure left an LED lit");
`endif

endmodule

`default_nettype wire

>>> verif/four_channel_led_blink_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_led_blink_engine_core_tb: self-checking bench of the blink engine
// Drives ticks and reconfigure items with random gaps on both channels, with
// short gap-free tick bursts at full rate. A scoreboard keeps its own copy of
// the LED counters and checks every result mask in order.
// ----------------------------------------------------------------------------
module four_channel_led_blink_engine_core_tb;
  import fclb_pkg::*;

  localparam int LONG_HOLD      = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int ROUNDS         = 8;
  localparam int SEGMENT_ITEMS  = 130;

  // Rate codes that the package leaves without a name.
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam logic [DUR_W-1:0] ON_US [8] = '{T_HALF_S, T_ONE_S, T_QUART_S, T_EIGHT_S,
                                             T_SIXT_S, T_ONE_S, T_ONE_S, T_ONE_S};
  localparam logic [DUR_W-1:0] OFF_US [8] = '{T_HALF_S, T_ONE_S, T_QUART_S, T_EIGHT_S,
                                              T_SIXT_S, T_THREE_S, T_ONE_S, T_ONE_S};
  localparam logic [DUR_W-1:0] RESET_US [4] = '{T_ONE_S, T_250MS, T_ONE_S, T_100MS};

  typedef struct packed {
    logic [MASK_W-1:0] lit;
    logic [MASK_W-1:0] red;
  } led_masks_t;

  class blink_scoreboard;
    logic [DUR_W-1:0] on_time [4];
    logic [DUR_W-1:0] off_time [4];
    logic [DUR_W-1:0] time_left [4];
    logic [MASK_W-1:0] lit;
    logic [MASK_W-1:0] red;
    led_masks_t pending_masks [$];
    int errors;
    int results_seen;

    function new();
      for (int i = 0; i < 4; i++) begin
        on_time[i]   = RESET_US[i];
        off_time[i]  = RESET_US[i];
        time_left[i] = RESET_US[i];
      end
      lit = '0;
      // Only the last LED starts red.
      red = 4'b1000;
      errors = 0;
      results_seen = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Advances the LED state by one accepted item and queues the masks it yields.
    function void apply_item(input item_t it);
      led_masks_t m;
      int ref_idx;
      logic [DUR_W-1:0] best;
      logic ref_lit;
      if (it.opcode == OP_RECONF) begin
        for (int i = 0; i < 4; i++) begin
          on_time[i]  = ON_US[it.mode[i]];
          off_time[i] = OFF_US[it.mode[i]];
          red[i]      = it.colour_mask[i];
        end
        ref_idx = -1;
        best = '0;
        for (int i = 0; i < 4; i++) begin
          if (!it.changed_mask[i] && (ref_idx < 0 || time_left[i] > best)) begin
            ref_idx = i;
            best = time_left[i];
          end
        end
        if (ref_idx < 0) begin
          for (int i = 0; i < 4; i++) begin
            lit[i] = 1'b0;
            time_left[i] = off_time[i];
          end
        end else begin
          ref_lit = lit[ref_idx];
          for (int i = 0; i < 4; i++) begin
            if (it.changed_mask[i]) begin
              lit[i] = ref_lit;
              time_left[i] = ref_lit ? on_time[i] : off_time[i];
            end
          end
        end
      end else begin
        for (int i = 0; i < 4; i++) begin
          // A count of one or zero both expire, so the counter never wraps.
          if (time_left[i] <= 1) begin
            lit[i] = ~lit[i];
            time_left[i] = lit[i] ? on_time[i] : off_time[i];
          end else begin
            time_left[i] = time_left[i] - 1'b1;
          end
        end
      end
      m.lit = lit;
      m.red = red;
      pending_masks.push_back(m);
    endfunction

    task check_masks(input logic [MASK_W-1:0] lit_got, input logic [MASK_W-1:0] red_got);
      led_masks_t exp;
      if (pending_masks.size() == 0) begin
        report_mismatch($sformatf("result lit=%h red=%h with no item outstanding",
                                  lit_got, red_got));
        return;
      end
      exp = pending_masks.pop_front();
      if (lit_got !== exp.lit)
        report_mismatch($sformatf("result %0d lit_mask %h, predicted %h",
                                  results_seen, lit_got, exp.lit));
      if (red_got !== exp.red)
        report_mismatch($sformatf("result %0d red_mask %h, predicted %h",
                                  results_seen, red_got, exp.red));
      results_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fclb_in_if  in_ch ();
  fclb_out_if out_ch ();

  four_channel_led_blink_engine_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  blink_scoreboard sb = new();

  bit src_quiet    = 1'b0;
  bit sink_quiet   = 1'b0;
  bit hold_request = 1'b0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    item_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_masks(out_ch.lit_mask, out_ch.red_mask);
      if (in_ch.valid && in_ch.ready) begin
        seen.opcode       = in_ch.opcode;
        seen.changed_mask = in_ch.changed_mask;
        seen.colour_mask  = in_ch.colour_mask;
        seen.mode[0]      = in_ch.mode_led0;
        seen.mode[1]      = in_ch.mode_led1;
        seen.mode[2]      = in_ch.mode_led2;
        seen.mode[3]      = in_ch.mode_led3;
        sb.apply_item(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, idle_cycles);
        $display("four_channel_led_blink_engine_core_tb: done, errors");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, with one long hold-off on request.
  initial begin : result_sink
    int wait_cycles;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        wait_cycles = LONG_HOLD;
      end else if (sink_quiet) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 4);
      end
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic item_t make_item(input op_t op, input logic [3:0] chg,
                                      input logic [3:0] col, input logic [2:0] m0,
                                      input logic [2:0] m1, input logic [2:0] m2,
                                      input logic [2:0] m3);
    item_t it;
    it.opcode = op;
    it.changed_mask = chg;
    it.colour_mask = col;
    it.mode[0] = m0;
    it.mode[1] = m1;
    it.mode[2] = m2;
    it.mode[3] = m3;
    return it;
  endfunction

  // Fast items favor the 62.5 ms and 125 ms rates.
  function automatic item_t random_item(input bit fast, input int reconf_pct);
    item_t it;
    int sel;
    it.opcode = ($urandom_range(0, 99) < reconf_pct) ? OP_RECONF : OP_TICK;
    sel = $urandom_range(0, 9);
    it.changed_mask = (sel == 0) ? 4'h0 : (sel == 1) ? 4'hF : 4'($urandom);
    it.colour_mask = 4'($urandom);
    for (int i = 0; i < 4; i++) begin
      if (fast && $urandom_range(0, 3) != 0)
        it.mode[i] = $urandom_range(0, 1) ? MODE_8HZ : MODE_4HZ;
      else
        it.mode[i] = 3'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= it.opcode;
    in_ch.changed_mask <= it.changed_mask;
    in_ch.colour_mask  <= it.colour_mask;
    in_ch.mode_led0    <= it.mode[0];
    in_ch.mode_led1    <= it.mode[1];
    in_ch.mode_led2    <= it.mode[2];
    in_ch.mode_led3    <= it.mode[3];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_masks.size() != 0);
  endtask

  initial begin : stimulus
    item_t it;
    int burst_len;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_TICK;
    in_ch.changed_mask <= '0;
    in_ch.colour_mask  <= '0;
    in_ch.mode_led0    <= MODE_1HZ;
    in_ch.mode_led1    <= MODE_1HZ;
    in_ch.mode_led2    <= MODE_1HZ;
    in_ch.mode_led3    <= MODE_1HZ;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every rate code, all and none flagged, ties.
    send_item(make_item(OP_TICK, 4'h0, 4'h0, MODE_1HZ, MODE_1HZ, MODE_1HZ, MODE_1HZ));
    send_item(make_item(OP_TICK, 4'hF, 4'hF, MODE_SPARE_B, MODE_SPARE_B, MODE_SPARE_B,
                        MODE_SPARE_B));
    send_item(make_item(OP_RECONF, 4'h0, 4'hF, MODE_1HZ, MODE_HALFHZ, MODE_2HZ, MODE_4HZ));
    send_item(make_item(OP_TICK, 4'h0, 4'h0, MODE_1HZ, MODE_1HZ, MODE_1HZ, MODE_1HZ));
    send_item(make_item(OP_RECONF, 4'h0, 4'h0, MODE_8HZ, MODE_QUARTHZ, MODE_SPARE_A,
                        MODE_SPARE_B));
    send_item(make_item(OP_RECONF, 4'hF, 4'hA, MODE_QUARTHZ, MODE_QUARTHZ, MODE_QUARTHZ,
                        MODE_QUARTHZ));
    send_item(make_item(OP_RECONF, 4'hF, 4'h5, MODE_HALFHZ, MODE_HALFHZ, MODE_HALFHZ,
                        MODE_HALFHZ));
    send_item(make_item(OP_RECONF, 4'hE, 4'h3, MODE_1HZ, MODE_2HZ, MODE_4HZ, MODE_8HZ));
    send_item(make_item(OP_TICK, 4'h0, 4'h0, MODE_1HZ, MODE_1HZ, MODE_1HZ, MODE_1HZ));
    send_item(make_item(OP_RECONF, 4'h1, 4'hC, MODE_8HZ, MODE_4HZ, MODE_2HZ, MODE_1HZ));
    send_item(make_item(OP_RECONF, 4'h2, 4'h9, MODE_QUARTHZ, MODE_SPARE_A, MODE_1HZ,
                        MODE_HALFHZ));
    send_item(make_item(OP_TICK, 4'h0, 4'h0, MODE_1HZ, MODE_1HZ, MODE_1HZ, MODE_1HZ));
    send_item(make_item(OP_RECONF, 4'h4, 4'h6, MODE_2HZ, MODE_2HZ, MODE_SPARE_B,
                        MODE_QUARTHZ));
    send_item(make_item(OP_RECONF, 4'h8, 4'hF, MODE_4HZ, MODE_8HZ, MODE_HALFHZ, MODE_1HZ));
    send_item(make_item(OP_RECONF, 4'h6, 4'h0, MODE_SPARE_A, MODE_1HZ, MODE_QUARTHZ,
                        MODE_2HZ));
    send_item(make_item(OP_RECONF, 4'h9, 4'h5, MODE_HALFHZ, MODE_QUARTHZ, MODE_8HZ,
                        MODE_4HZ));
    send_item(make_item(OP_TICK, 4'hF, 4'hF, MODE_SPARE_B, MODE_SPARE_B, MODE_SPARE_B,
                        MODE_SPARE_B));
    send_item(make_item(OP_TICK, 4'h0, 4'h0, MODE_1HZ, MODE_1HZ, MODE_1HZ, MODE_1HZ));

    for (int r = 0; r < ROUNDS; r++) begin
      if (r == 2) begin
        // Receiver stalls while the sender keeps offering, so the block backs up.
        src_quiet = 1'b1;
        hold_request = 1'b1;
        repeat (30) send_item(random_item(1'b0, 30));
        src_quiet = 1'b0;
      end
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        if (r == 4 && k == SEGMENT_ITEMS / 2)
          drain_results();
        send_item(random_item(r[0], 30));
      end
      if (r[0]) begin
        // Gap-free tick burst with both sides running at full rate.
        drain_results();
        it = random_item(1'b1, 100);
        if ($urandom_range(0, 1))
          it.changed_mask = 4'hF;
        send_item(it);
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        burst_len = $urandom_range(10, 20);
        repeat (burst_len) send_item(random_item(1'b0, 0));
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_masks.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_masks.size()));
    if (sb.errors == 0) begin
      $display("four_channel_led_blink_engine_core_tb: done, clean");
    end else begin
      $display("four_channel_led_blink_engine_core_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/fclb_pkg.sv
hdl/fclb_in_if.sv
hdl/fclb_out_if.sv
hdl/fclb_ref_sel.sv
hdl/fclb_led.sv
hdl/four_channel_led_blink_engine_core.sv
verif/four_channel_led_blink_engine_core_tb.sv
